FILE: src/gtc_pkg.sv
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, codes and constants of the tilt and shake gesture classifier.
// ----------------------------------------------------------------------------
package gtc_pkg;

	// Data widths
	localparam int unsigned SmoothW = 24;
	localparam int unsigned TimeW   = 32;

	// Default build values
	localparam int unsigned DefMedianTaps  = 5;
	localparam int unsigned DefShakeExtra  = 500;
	localparam int unsigned ShakeExtraW    = 12;

	// One g in filter units (4096 << 8)
	localparam logic signed [SmoothW-1:0] OneGFix = 24'sd1048576;

	// Gesture codes
	typedef enum logic [2:0] {
		GEST_NONE       = 3'd0,
		GEST_SHAKE      = 3'd1,
		GEST_ROLL_DOWN  = 3'd2,
		GEST_ROLL_UP    = 3'd3,
		GEST_PITCH_FWD  = 3'd4,
		GEST_PITCH_BACK = 3'd5
	} gest_t;

	// Configuration register indexes
	localparam logic [2:0] REG_GYRO_OFFSET_X   = 3'd0;
	localparam logic [2:0] REG_GYRO_OFFSET_Y   = 3'd1;
	localparam logic [2:0] REG_SMOOTHING_ALPHA = 3'd2;
	localparam logic [2:0] REG_SHAKE_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_PITCH_THRESHOLD = 3'd4;
	localparam logic [2:0] REG_ROLL_THRESHOLD  = 3'd5;
	localparam logic [2:0] REG_BLANKING_MS     = 3'd6;
	localparam logic [2:0] REG_ANALYSIS_WIN_MS = 3'd7;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_UPD,
		ST_CHK,
		ST_SORT,
		ST_MED,
		ST_DEC
	} state_t;

	// Control word for a row of median cells
	typedef struct packed {
		logic push;
		logic step;
	} cell_ctl_t;

endpackage

FILE: src/gtc_smoother.sv
// ----------------------------------------------------------------------------
// gtc_smoother
// First-order low-pass filter with 8 fraction bits, round half up.
// ----------------------------------------------------------------------------
module gtc_smoother #(
	parameter logic signed [23:0] INIT = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               mul_en,
	input  logic               upd_en,
	input  logic signed [15:0] sample,
	input  logic        [15:0] alpha,
	output logic signed [23:0] value
);
	import gtc_pkg::*;

	logic signed [SmoothW-1:0] value_q;
	logic signed [SmoothW:0]   diff;
	logic signed [41:0]        prod_s1;
	logic signed [41:0]        rnd;

	// distance from the held value to the new sample
	assign diff = $signed({sample[15], sample, 8'b0}) - $signed({value_q[SmoothW-1], value_q});
	assign rnd  = prod_s1 + 42'sd32768;

	// multiply by the weight
	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_s1 <= $signed({1'b0, alpha}) * diff;
		end
	end

	// advance the held value by the rounded step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			value_q <= INIT;
		end else if (upd_en) begin
			value_q <= value_q + rnd[16 +: SmoothW];
		end
	end

	assign value = value_q;

endmodule

FILE: src/gtc_median_cell.sv
// ----------------------------------------------------------------------------
// gtc_median_cell
// One tap of a rolling median window; ranks its value against a rotating copy.
// ----------------------------------------------------------------------------
module gtc_median_cell #(
	parameter int unsigned CW = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gtc_pkg::cell_ctl_t    ctl,
	input  logic signed [23:0]    shift_in,
	input  logic signed [23:0]    rot_in,
	output logic signed [23:0]    stored,
	output logic signed [23:0]    rot,
	output logic        [CW-1:0]  lt_cnt,
	output logic        [CW-1:0]  le_cnt
);
	import gtc_pkg::*;

	logic signed [SmoothW-1:0] stored_q;
	logic signed [SmoothW-1:0] rot_q;
	logic        [CW-1:0]      lt_q;
	logic        [CW-1:0]      le_q;

	// shift the window on push, clear the cell reset value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_q <= '0;
		end else if (ctl.push) begin
			stored_q <= shift_in;
		end
	end

	// load the rotating copy on push, then rotate and count
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			rot_q <= shift_in;
			lt_q  <= '0;
			le_q  <= '0;
		end else if (ctl.step) begin
			rot_q <= rot_in;
			lt_q  <= lt_q + CW'(rot_q < stored_q);
			le_q  <= le_q + CW'(rot_q <= stored_q);
		end
	end

	assign stored = stored_q;
	assign rot    = rot_q;
	assign lt_cnt = lt_q;
	assign le_cnt = le_q;

endmodule

FILE: src/gtc_median_row.sv
// ----------------------------------------------------------------------------
// gtc_median_row
// Row of median cells; the median is the cell whose rank covers the middle.
// ----------------------------------------------------------------------------
module gtc_median_row #(
	parameter int unsigned TAPS = gtc_pkg::DefMedianTaps
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gtc_pkg::cell_ctl_t ctl,
	input  logic signed [23:0] new_value,
	output logic signed [23:0] median
);
	import gtc_pkg::*;

	localparam int unsigned CW  = $clog2(TAPS + 1);
	localparam logic [CW-1:0] MID = CW'(TAPS / 2);

	logic signed [SmoothW-1:0] stored [TAPS];
	logic signed [SmoothW-1:0] rot    [TAPS];
	logic        [CW-1:0]      lt_cnt [TAPS];
	logic        [CW-1:0]      le_cnt [TAPS];

	genvar gi;
	generate
		for (gi = 0; gi < TAPS; gi++) begin : g_cell
			gtc_median_cell #(.CW(CW)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctl      (ctl),
				.shift_in ((gi == 0) ? new_value : stored[(gi + TAPS - 1) % TAPS]),
				.rot_in   (rot[(gi + TAPS - 1) % TAPS]),
				.stored   (stored[gi]),
				.rot      (rot[gi]),
				.lt_cnt   (lt_cnt[gi]),
				.le_cnt   (le_cnt[gi])
			);
		end
	endgenerate

	// merge the selected cells; all of them hold the same value
	always_comb begin
		median = '0;
		for (int i = 0; i < TAPS; i++) begin
			if (lt_cnt[i] <= MID && le_cnt[i] > MID) begin
				median = median | stored[i];
			end
		end
	end

endmodule

FILE: src/imu_tilt_gesture_classifier.sv
// Each accepted word passes the multiply, update and check states, the median
// cell row rotation (MEDIAN_TAPS steps, skipped on a shake) and the decision
// state; no new word is accepted until the result word has been loaded.
// Reset: arst_n clears filters, windows, gesture tracking and registers to
// their defaults at once; no clearing pass.
// ----------------------------------------------------------------------------
// imu_tilt_gesture_classifier
// Filters IMU samples, classifies shake, pitch and roll, and emits verdicts.
// ----------------------------------------------------------------------------
module imu_tilt_gesture_classifier #(
	parameter int unsigned MEDIAN_TAPS    = gtc_pkg::DefMedianTaps,
	parameter int unsigned SHAKE_EXTRA_MS = gtc_pkg::DefShakeExtra
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] gyro_x,
	input  logic signed [15:0] gyro_y,
	input  logic        [31:0] time_ms,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [2:0]  gesture,
	output logic        [2:0]  instant_status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [2:0]  cfg_index,
	input  logic        [15:0] cfg_data
);
	import gtc_pkg::*;

	localparam int unsigned SCW = (MEDIAN_TAPS > 1) ? $clog2(MEDIAN_TAPS) : 1;
	localparam logic [SCW-1:0] SortLast = SCW'(MEDIAN_TAPS - 1);
	localparam logic [16:0] ShakeExtra = 17'(SHAKE_EXTRA_MS);

	// configuration registers
	logic signed [15:0] off_x_q, off_y_q;
	logic        [15:0] alpha_q, blank_ms_q, win_ms_q;
	logic        [14:0] shake_thr_q, pitch_thr_q, roll_thr_q;

	// accepted sample
	logic signed [15:0] az_s1, gx_s1, gy_s1;
	logic        [TimeW-1:0] now_s1;
	logic signed [16:0] gx_diff, gy_diff;
	logic signed [15:0] gx_sat, gy_sat;

	// sequencer
	state_t state_q, state_d;
	logic [SCW-1:0] sort_cnt_q;
	logic mul_en, upd_en, accept, out_load;
	cell_ctl_t cell_ctl;

	// filters and medians
	logic signed [SmoothW-1:0] s_az, s_gx, s_gy, med_x, med_y;
	logic signed [SmoothW:0]   dz, mx_ext, my_ext;
	logic        [SmoothW:0]   dz_mag, mx_mag, my_mag;
	logic                      shake;
	gest_t                     med_cls;
	gest_t                     inst_q;

	// gesture tracking
	gest_t pending_q;
	logic  collecting_q, last_shake_q;
	logic [TimeW-1:0] start_ms_q, last_emit_q, since_emit, since_start;
	logic [16:0] blank_len;
	gest_t result;

	// output word
	logic  out_valid_q;
	gest_t gesture_q, status_q;

	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// write configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q     <= '0;
			off_y_q     <= '0;
			alpha_q     <= 16'd13107;
			shake_thr_q <= 15'd2048;
			pitch_thr_q <= 15'd1600;
			roll_thr_q  <= 15'd1600;
			blank_ms_q  <= 16'd500;
			win_ms_q    <= 16'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GYRO_OFFSET_X:   off_x_q     <= cfg_data;
				REG_GYRO_OFFSET_Y:   off_y_q     <= cfg_data;
				REG_SMOOTHING_ALPHA: alpha_q     <= cfg_data;
				REG_SHAKE_THRESHOLD: shake_thr_q <= cfg_data[14:0];
				REG_PITCH_THRESHOLD: pitch_thr_q <= cfg_data[14:0];
				REG_ROLL_THRESHOLD:  roll_thr_q  <= cfg_data[14:0];
				REG_BLANKING_MS:     blank_ms_q  <= cfg_data;
				REG_ANALYSIS_WIN_MS: win_ms_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// remove gyro bias and saturate
	assign gx_diff = $signed({gyro_x[15], gyro_x}) - $signed({off_x_q[15], off_x_q});
	assign gy_diff = $signed({gyro_y[15], gyro_y}) - $signed({off_y_q[15], off_y_q});
	assign gx_sat  = (gx_diff[16] != gx_diff[15]) ? {gx_diff[16], {15{~gx_diff[16]}}}
	                                              : gx_diff[15:0];
	assign gy_sat  = (gy_diff[16] != gy_diff[15]) ? {gy_diff[16], {15{~gy_diff[16]}}}
	                                              : gy_diff[15:0];

	// hold the accepted word
	always_ff @(posedge clk) begin
		if (accept) begin
			az_s1  <= accel_z;
			gx_s1  <= gx_sat;
			gy_s1  <= gy_sat;
			now_s1 <= time_ms;
		end
	end

	gtc_smoother #(.INIT(OneGFix)) u_smooth_az (
		.clk(clk), .arst_n(arst_n), .mul_en(mul_en), .upd_en(upd_en),
		.sample(az_s1), .alpha(alpha_q), .value(s_az)
	);
	gtc_smoother #(.INIT('0)) u_smooth_gx (
		.clk(clk), .arst_n(arst_n), .mul_en(mul_en), .upd_en(upd_en),
		.sample(gx_s1), .alpha(alpha_q), .value(s_gx)
	);
	gtc_smoother #(.INIT('0)) u_smooth_gy (
		.clk(clk), .arst_n(arst_n), .mul_en(mul_en), .upd_en(upd_en),
		.sample(gy_s1), .alpha(alpha_q), .value(s_gy)
	);

	gtc_median_row #(.TAPS(MEDIAN_TAPS)) u_row_x (
		.clk(clk), .arst_n(arst_n), .ctl(cell_ctl), .new_value(s_gx), .median(med_x)
	);
	gtc_median_row #(.TAPS(MEDIAN_TAPS)) u_row_y (
		.clk(clk), .arst_n(arst_n), .ctl(cell_ctl), .new_value(s_gy), .median(med_y)
	);

	// shake test on the filtered accel Z
	assign dz     = $signed({s_az[SmoothW-1], s_az}) - $signed({OneGFix[SmoothW-1], OneGFix});
	assign dz_mag = dz[SmoothW] ? $unsigned(-dz) : $unsigned(dz);
	assign shake  = dz_mag > {2'b0, shake_thr_q, 8'b0};

	// pitch, then roll, on the medians
	assign mx_ext = {med_x[SmoothW-1], med_x};
	assign my_ext = {med_y[SmoothW-1], med_y};
	assign mx_mag = mx_ext[SmoothW] ? $unsigned(-mx_ext) : $unsigned(mx_ext);
	assign my_mag = my_ext[SmoothW] ? $unsigned(-my_ext) : $unsigned(my_ext);

	always_comb begin
		if (mx_mag > {2'b0, pitch_thr_q, 8'b0}) begin
			med_cls = med_x[SmoothW-1] ? GEST_PITCH_FWD : GEST_PITCH_BACK;
		end else if (my_mag > {2'b0, roll_thr_q, 8'b0}) begin
			med_cls = med_y[SmoothW-1] ? GEST_ROLL_DOWN : GEST_ROLL_UP;
		end else begin
			med_cls = GEST_NONE;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_MUL;
			ST_MUL:  state_d = ST_UPD;
			ST_UPD:  state_d = ST_CHK;
			ST_CHK:  state_d = shake ? ST_DEC : ST_SORT;
			ST_SORT: if (sort_cnt_q == SortLast) state_d = ST_MED;
			ST_MED:  state_d = ST_DEC;
			ST_DEC:  if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready      = 1'b0;
		mul_en        = 1'b0;
		upd_en        = 1'b0;
		cell_ctl.push = 1'b0;
		cell_ctl.step = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = 1'b1;
			ST_MUL:  mul_en = 1'b1;
			ST_UPD:  upd_en = 1'b1;
			ST_CHK:  cell_ctl.push = !shake;
			ST_SORT: cell_ctl.step = 1'b1;
			ST_DEC:  out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count rotation steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sort_cnt_q <= '0;
		end else if (state_q == ST_SORT) begin
			sort_cnt_q <= (sort_cnt_q == SortLast) ? '0 : sort_cnt_q + 1'b1;
		end
	end

	// latch this sample's classification
	always_ff @(posedge clk) begin
		if (state_q == ST_CHK && shake) begin
			inst_q <= GEST_SHAKE;
		end else if (state_q == ST_MED) begin
			inst_q <= med_cls;
		end
	end

	// blanking and analysis window timing
	assign blank_len   = {1'b0, blank_ms_q} + (last_shake_q ? ShakeExtra : 17'd0);
	assign since_emit  = now_s1 - last_emit_q;
	assign since_start = now_s1 - start_ms_q;

	always_comb begin
		result = GEST_NONE;
		if (since_emit >= {15'b0, blank_len} && collecting_q &&
		    since_start >= {16'b0, win_ms_q}) begin
			result = pending_q;
		end
	end

	// track the pending gesture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q    <= GEST_NONE;
			collecting_q <= 1'b0;
			start_ms_q   <= '0;
			last_emit_q  <= '0;
			last_shake_q <= 1'b0;
		end else if (out_load && since_emit >= {15'b0, blank_len}) begin
			if (!collecting_q) begin
				if (inst_q != GEST_NONE) begin
					pending_q    <= inst_q;
					start_ms_q   <= now_s1;
					collecting_q <= 1'b1;
				end
			end else if (since_start < {16'b0, win_ms_q}) begin
				if ((pending_q == GEST_PITCH_FWD || pending_q == GEST_PITCH_BACK) &&
				    inst_q == GEST_SHAKE) begin
					pending_q <= GEST_SHAKE;
				end
			end else begin
				collecting_q <= 1'b0;
				pending_q    <= GEST_NONE;
				if (pending_q != GEST_NONE) begin
					last_emit_q  <= now_s1;
					last_shake_q <= (pending_q == GEST_SHAKE);
				end
			end
		end
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output word payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			gesture_q <= result;
			status_q  <= inst_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign gesture        = gesture_q;
	assign instant_status = status_q;

endmodule
